>>> rtl/pwga_pkg.sv
// ----------------------------------------------------------------------------
// pwga_pkg: shared constants and helpers
// Sizes, operation codes and register indexes of the weighted Gram accumulator.
// ----------------------------------------------------------------------------
package pwga_pkg;

  localparam int ROWS      = 256;
  localparam int MAX_TERMS = 8;
  localparam int POINTS    = 256;
  localparam int TRI       = MAX_TERMS * (MAX_TERMS + 1) / 2;
  localparam int MOM_DEPTH = ROWS * TRI;
  localparam int RHS_DEPTH = ROWS * MAX_TERMS;
  localparam int BAS_DEPTH = POINTS * MAX_TERMS;
  localparam int MOM_AW    = $clog2(MOM_DEPTH);
  localparam int RHS_AW    = $clog2(RHS_DEPTH);
  localparam int BAS_AW    = $clog2(BAS_DEPTH);
  localparam int TRI_AW    = $clog2(TRI);

  localparam logic [1:0] OP_BASIS    = 2'd0;
  localparam logic [1:0] OP_RESPONSE = 2'd1;
  localparam logic [1:0] OP_PAIR     = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  localparam logic REG_TERM_COUNT    = 1'b0;
  localparam logic REG_TRACK_SUPPORT = 1'b1;

  localparam logic [3:0] RHS_COL = 4'd8;

  // Offset of element (a, b), a <= b, in a packed upper triangle.
  function automatic logic [TRI_AW-1:0] tri_idx(input logic [2:0] a, input logic [2:0] b);
    logic [7:0] base;
    base = 8'(a) * 8'(MAX_TERMS) - ((8'(a) * (8'(a) - 8'd1)) >> 1) + 8'(b) - 8'(a);
    return TRI_AW'(base);
  endfunction

endpackage

>>> rtl/pwga_mul.sv
// ----------------------------------------------------------------------------
// pwga_mul: shared multiplier
// Unsigned 32 x 32 product with a registered result, one product a cycle.
// ----------------------------------------------------------------------------
module pwga_mul import pwga_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

>>> rtl/pairwise_weighted_gram_accumulator.sv
// ----------------------------------------------------------------------------
// pairwise_weighted_gram_accumulator: weighted normal-equation accumulator
// Per-point basis and response stores, per-row moment triangles, right-hand
// sides and support counts, updated by weighted pair requests.
// ----------------------------------------------------------------------------
//  port group   dir  contents
//  s_*          in   requests: tuser = op, tdata = rows, points, terms, value
//  m_*          out  one result per request: read_value, support, overflow
//  APB          in   term_count (0x0), track_support (0x4)
//
// Writes and zero-weight pairs post their result in the cycle after acceptance,
// reads after S_RD0 and S_RD1. A pair passes S_SB0 to S_SB3 for support counting
// when enabled, S_LD, S_M1, S_M2, S_M3, S_SUM, S_NEG and S_WR per contribution on
// the shared multiplier and S_FIN to post the result: n * (n + 3) contributions.
// After reset a clearing pass zeroes the moment, rhs and support memories; no
// request is taken meanwhile. A new request is taken only when the block is
// idle and the result register is empty.
module pairwise_weighted_gram_accumulator import pwga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // fixed_row, moving_row, fixed_point_index,
                                 // moving_point_index, term_a, term_b, value, pad
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // read_value, support, overflow, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_SB0  = 4'd4;
  localparam logic [3:0] S_SB1  = 4'd5;
  localparam logic [3:0] S_SB2  = 4'd6;
  localparam logic [3:0] S_SB3  = 4'd7;
  localparam logic [3:0] S_LD   = 4'd8;
  localparam logic [3:0] S_M1   = 4'd9;
  localparam logic [3:0] S_M2   = 4'd10;
  localparam logic [3:0] S_M3   = 4'd11;
  localparam logic [3:0] S_SUM  = 4'd12;
  localparam logic [3:0] S_NEG  = 4'd13;
  localparam logic [3:0] S_WR   = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0]  state;
  logic [3:0]  term_count;
  logic        track_support;
  logic        sat_flag;
  logic [MOM_AW-1:0] clr_cnt;

  logic [7:0]  cur_row, cur_pt, mrow_r, fpt_r;
  logic [2:0]  a_idx;
  logic [3:0]  b_idx;
  logic        phase;
  logic        rd_ok;
  logic [31:0] weight;
  logic [31:0] m1_hi;
  logic [63:0] lo_r, c_r;
  logic signed [63:0] contrib;

  logic [31:0] bas_mem [BAS_DEPTH];
  logic [31:0] resp_mem [POINTS];
  logic [63:0] mom_mem [MOM_DEPTH];
  logic [63:0] rhs_mem [RHS_DEPTH];
  logic [3:0]  sup_mem [ROWS];
  logic [31:0] bas_a_rd, bas_b_rd, resp_rd;
  logic [63:0] mom_rd, rhs_rd;
  logic [3:0]  sup_rd;

  // Request fields
  logic [1:0]  in_op;
  logic [7:0]  in_frow, in_mrow, in_fpt, in_mpt;
  logic [2:0]  in_ta;
  logic [3:0]  in_tb;
  logic [31:0] in_val;
  assign in_op   = s_tuser;
  assign in_frow = s_tdata[7:0];
  assign in_mrow = s_tdata[15:8];
  assign in_fpt  = s_tdata[23:16];
  assign in_mpt  = s_tdata[31:24];
  assign in_ta   = s_tdata[34:32];
  assign in_tb   = s_tdata[38:35];
  assign in_val  = s_tdata[70:39];

  logic [3:0] n_eff;
  always_comb begin
    if (term_count == 4'd0) n_eff = 4'd1;
    else if (term_count > 4'(MAX_TERMS)) n_eff = 4'(MAX_TERMS);
    else n_eff = term_count;
  end

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  logic in_acc;
  assign in_acc = s_tvalid && s_tready;

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      REG_TERM_COUNT:    prdata = {28'd0, term_count};
      REG_TRACK_SUPPORT: prdata = {31'd0, track_support};
      default:           prdata = 32'd0;
    endcase
  end

  // Addresses
  logic [MOM_AW-1:0] mom_addr;
  logic [RHS_AW-1:0] rhs_addr;
  logic [BAS_AW-1:0] bas_a_addr, bas_b_addr;
  logic [7:0]        sup_addr;
  assign mom_addr   = (state == S_CLR) ? clr_cnt :
                      MOM_AW'({cur_row, 5'd0}) + MOM_AW'({cur_row, 2'd0}) +
                      MOM_AW'(tri_idx(a_idx, b_idx[2:0]));
  assign rhs_addr   = (state == S_CLR) ? clr_cnt[RHS_AW-1:0] : {cur_row, a_idx};
  assign bas_a_addr = {cur_pt, a_idx};
  assign bas_b_addr = {cur_pt, b_idx[2:0]};
  always_comb begin
    if (state == S_CLR) sup_addr = clr_cnt[7:0];
    else if (state == S_SB2 || state == S_SB3) sup_addr = mrow_r;
    else sup_addr = cur_row;
  end

  // Arithmetic path
  logic        is_rhs;
  logic [31:0] q_val, w_mag, p_mag, q_mag;
  logic        neg;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] lor;
  logic [63:0] acc_rd;
  logic signed [64:0] sum_x;
  logic signed [63:0] sat_val;
  logic        sat_hit;

  assign is_rhs = (b_idx == RHS_COL);
  assign q_val  = is_rhs ? resp_rd : bas_b_rd;
  assign w_mag  = weight[31] ? 32'(-weight) : weight;
  assign p_mag  = bas_a_rd[31] ? 32'(-bas_a_rd) : bas_a_rd;
  assign q_mag  = q_val[31] ? 32'(-q_val) : q_val;
  assign neg    = weight[31] ^ bas_a_rd[31] ^ q_val[31];

  always_comb begin
    unique case (state)
      S_M2:    begin mul_a = prod[31:0]; mul_b = q_mag; end
      S_M3:    begin mul_a = m1_hi;      mul_b = q_mag; end
      default: begin mul_a = w_mag;      mul_b = p_mag; end
    endcase
  end

  pwga_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  assign lor    = lo_r + 64'h0000_0080_0000_0000;
  assign acc_rd = is_rhs ? rhs_rd : mom_rd;
  assign sum_x  = 65'(signed'(acc_rd)) + 65'(contrib);
  always_comb begin
    sat_hit = 1'b0;
    sat_val = sum_x[63:0];
    if (sum_x[64] != sum_x[63]) begin
      sat_hit = 1'b1;
      sat_val = sum_x[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
  end

  // Memories
  logic mem_wr;
  assign mem_wr = (state == S_WR);
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_BASIS) bas_mem[{in_mpt, in_ta}] <= in_val;
    bas_a_rd <= bas_mem[bas_a_addr];
    bas_b_rd <= bas_mem[bas_b_addr];
  end
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_RESPONSE) resp_mem[in_mpt] <= in_val;
    resp_rd <= resp_mem[cur_pt];
  end
  always_ff @(posedge clk) begin
    if (state == S_CLR) mom_mem[mom_addr] <= 64'd0;
    else if (mem_wr && !is_rhs) mom_mem[mom_addr] <= sat_val;
    mom_rd <= mom_mem[mom_addr];
  end
  always_ff @(posedge clk) begin
    if (state == S_CLR) rhs_mem[rhs_addr] <= 64'd0;
    else if (mem_wr && is_rhs) rhs_mem[rhs_addr] <= sat_val;
    rhs_rd <= rhs_mem[rhs_addr];
  end
  always_ff @(posedge clk) begin
    if (state == S_CLR) sup_mem[sup_addr] <= 4'd0;
    else if ((state == S_SB1 || state == S_SB3) && sup_rd < n_eff)
      sup_mem[sup_addr] <= sup_rd + 4'd1;
    sup_rd <= sup_mem[sup_addr];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_M2:    m1_hi <= prod[63:32];
      S_M3:    lo_r <= prod;
      S_SUM:   c_r <= {32'd0, lor[63:32]} + prod;
      S_NEG:   contrib <= neg ? -signed'({8'd0, c_r[63:8]}) : signed'({8'd0, c_r[63:8]});
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      term_count    <= 4'd1;
      track_support <= 1'b0;
      sat_flag      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_TERM_COUNT) term_count <= pwdata[3:0];
        else track_support <= pwdata[0];
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == MOM_AW'(MOM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            cur_row <= in_frow;
            cur_pt  <= in_mpt;
            mrow_r  <= in_mrow;
            fpt_r   <= in_fpt;
            weight  <= in_val;
            phase   <= 1'b0;
            if (in_op == OP_READ) begin
              rd_ok <= (4'(in_ta) < n_eff) && (in_tb == RHS_COL || in_tb < n_eff);
              if (in_tb == RHS_COL || 4'(in_ta) <= in_tb) begin
                a_idx <= in_ta;
                b_idx <= in_tb;
              end else begin
                a_idx <= in_tb[2:0];
                b_idx <= 4'(in_ta);
              end
              state <= S_RD0;
            end else if (in_op == OP_PAIR && in_val != 32'd0) begin
              a_idx <= 3'd0;
              b_idx <= RHS_COL;
              state <= track_support ? S_SB0 : S_LD;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= {3'd0, sat_flag, 4'd0, 64'd0};
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {3'd0, sat_flag, sup_rd,
                       rd_ok ? (is_rhs ? rhs_rd : mom_rd) : 64'd0};
          state    <= S_IDLE;
        end
        S_SB0: state <= S_SB1;
        S_SB1: state <= S_SB2;
        S_SB2: state <= S_SB3;
        S_SB3: state <= S_LD;
        S_LD:  state <= S_M1;
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_SUM;
        S_SUM: state <= S_NEG;
        S_NEG: state <= S_WR;
        S_WR: begin
          if (sat_hit) sat_flag <= 1'b1;
          state <= S_LD;
          if (is_rhs) begin
            b_idx <= 4'(a_idx);
          end else if (b_idx + 4'd1 < n_eff) begin
            b_idx <= b_idx + 4'd1;
          end else if (4'(a_idx) + 4'd1 < n_eff) begin
            a_idx <= a_idx + 3'd1;
            b_idx <= RHS_COL;
          end else if (!phase) begin
            // Second half: the partner row takes the fixed point's terms.
            phase   <= 1'b1;
            a_idx   <= 3'd0;
            b_idx   <= RHS_COL;
            cur_row <= mrow_r;
            cur_pt  <= fpt_r;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {3'd0, sat_flag, 4'd0, 64'd0};
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    sat_flag |=> sat_flag) else $error("saturation flag cleared");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !m_tvalid) else $error("work started with result pending");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (4'(a_idx) < n_eff) && (b_idx == RHS_COL || b_idx < n_eff))
    else $error("term index out of range");

  a_rhs_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && is_rhs) |=> (b_idx == 4'(a_idx)))
    else $error("moment row did not follow rhs step");

endmodule

>>> dv/pairwise_weighted_gram_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_weighted_gram_accumulator_tb: self-checking bench for the Gram
// accumulator
// Loads point data, runs directed and random pair, write and read requests
// under several term counts and support settings, predicts every result with
// an in-bench model of the accumulators and compares each result field.
// ----------------------------------------------------------------------------
module pairwise_weighted_gram_accumulator_tb;
  import pwga_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 800;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  term_b;
    logic [2:0]  term_a;
    logic [7:0]  mpt;
    logic [7:0]  fpt;
    logic [7:0]  mrow;
    logic [7:0]  frow;
  } req_t;

  typedef struct packed {
    logic        overflow;
    logic [3:0]  support;
    logic [63:0] read_value;
  } res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // fixed_row, moving_row, fixed_point_index,
                          // moving_point_index, term_a, term_b, value, pad
  logic [1:0]  s_tuser;   // op
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // read_value, support, overflow, pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pairwise_weighted_gram_accumulator dut (.*);

  // Model state.
  logic [3:0]         term_count_reg;
  logic               track_reg;
  logic signed [31:0] basis_mem [256][8];
  logic signed [31:0] resp_mem [256];
  logic [7:0]         basis_written [256];
  bit                 resp_written [256];
  longint             moment_acc [256][8][8];
  longint             rhs_acc [256][8];
  logic [3:0]         support_cnt [256];
  bit                 sat_seen;

  res_t   expected_results [$];
  int     error_count;
  bit     idle_on;
  bit     hold_results;
  int     result_gap;
  int     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag32(logic signed [31:0] v);
    logic [63:0] r;
    r = 64'(longint'(v));
    if (v < 0) r = -r;
    return r;
  endfunction

  // Exact product of three Q8.24 values, rounded to Q32.32 half away from zero.
  function automatic longint triple_q(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z);
    logic [63:0] m1, uc, lo, hi, c, mg;
    bit neg;
    neg = (x < 0) ^ (y < 0) ^ (z < 0);
    m1 = mag32(x) * mag32(y);
    uc = mag32(z);
    lo = {32'd0, m1[31:0]} * uc;
    hi = (m1 >> 32) * uc;
    c  = ((lo + (64'd1 << 39)) >> 32) + hi;
    mg = c >> 8;
    return neg ? -longint'(mg) : longint'(mg);
  endfunction

  function automatic longint sat_add(longint acc, longint v);
    logic signed [64:0] s;
    s = {acc[63], acc} + {v[63], v};
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    end
    return longint'(s[63:0]);
  endfunction

  function automatic int active_terms();
    if (term_count_reg == 0) return 1;
    if (term_count_reg > MAX_TERMS) return MAX_TERMS;
    return term_count_reg;
  endfunction

  function automatic void add_point(int row, int pt, logic signed [31:0] w, int n);
    for (int a = 0; a < n; a++) begin
      rhs_acc[row][a] = sat_add(rhs_acc[row][a],
                                triple_q(w, basis_mem[pt][a], resp_mem[pt]));
      for (int b = a; b < n; b++)
        moment_acc[row][a][b] = sat_add(moment_acc[row][a][b],
                                        triple_q(w, basis_mem[pt][a], basis_mem[pt][b]));
    end
  endfunction

  function automatic void bump_support(int row, int n);
    if (support_cnt[row] < n) support_cnt[row]++;
  endfunction

  function automatic res_t predict_result(logic [1:0] op, req_t r);
    res_t e;
    int n;
    int lo, hi;
    n = active_terms();
    e = '0;
    case (op)
      OP_BASIS: begin
        basis_mem[r.mpt][r.term_a] = r.value;
        basis_written[r.mpt][r.term_a] = 1'b1;
      end
      OP_RESPONSE: begin
        resp_mem[r.mpt] = r.value;
        resp_written[r.mpt] = 1'b1;
      end
      OP_PAIR: begin
        if (r.value != 0) begin
          if (track_reg) begin
            bump_support(r.frow, n);
            bump_support(r.mrow, n);
          end
          add_point(r.frow, r.mpt, r.value, n);
          add_point(r.mrow, r.fpt, r.value, n);
        end
      end
      default: begin
        e.support = support_cnt[r.frow];
        if (r.term_a < n) begin
          if (r.term_b == RHS_COL) begin
            e.read_value = rhs_acc[r.frow][r.term_a];
          end else if (r.term_b < n) begin
            lo = (r.term_a < r.term_b) ? r.term_a : r.term_b;
            hi = (r.term_a < r.term_b) ? r.term_b : r.term_a;
            e.read_value = moment_acc[r.frow][lo][hi];
          end
        end
      end
    endcase
    e.overflow = sat_seen;
    return e;
  endfunction

  function automatic req_t mk_req(int frow, int mrow, int fpt, int mpt, int ta, int tb,
                                  logic [31:0] v);
    req_t r;
    r.frow = 8'(frow); r.mrow = 8'(mrow); r.fpt = 8'(fpt); r.mpt = 8'(mpt);
    r.term_a = 3'(ta); r.term_b = 4'(tb); r.value = v;
    return r;
  endfunction

  function automatic int pick_ready_point();
    int p;
    do p = $urandom_range(0, 255);
    while (!(basis_written[p] == 8'hFF && resp_written[p]));
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    error_count++;
  endtask

  task automatic send_request(logic [1:0] op, req_t r);
    int gap;
    res_t e;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, r};
    do @(posedge clk); while (!s_tready);
    e = predict_result(op, r);
    expected_results.push_back(e);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_TERM_COUNT) term_count_reg = data[3:0];
    else track_reg = data[0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [3:0] tc, logic trk);
    wait_idle();
    reg_write(REG_TERM_COUNT, 32'(tc));
    reg_write(REG_TRACK_SUPPORT, 32'(trk));
  endtask

  // Random request with content biased toward well-formed pairs and reads.
  task automatic send_random(int row_span);
    int sel;
    req_t r;
    r = mk_req($urandom_range(0, row_span), $urandom_range(0, row_span),
               pick_ready_point(), pick_ready_point(), $urandom_range(0, 7),
               $urandom_range(0, 15), $urandom);
    if ($urandom_range(0, 3) == 0) r.term_b = 4'($urandom_range(0, 8));
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      r.mpt = 8'($urandom_range(0, 255));
      send_request(OP_BASIS, r);
    end else if (sel < 17) begin
      r.mpt = 8'($urandom_range(0, 255));
      send_request(OP_RESPONSE, r);
    end else if (sel < 52) begin
      if ($urandom_range(0, 19) == 0) r.value = '0;
      send_request(OP_PAIR, r);
    end else begin
      send_request(OP_READ, r);
    end
  endtask

  task automatic test_load_points();
    int p;
    for (int k = 0; k < 24; k++) begin
      p = (k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(0, 255);
      for (int t = 0; t < 8; t++)
        send_request(OP_BASIS, mk_req(0, 0, 0, p, t, 0, $urandom));
      send_request(OP_RESPONSE, mk_req(0, 0, 0, p, 0, 0, $urandom));
    end
  endtask

  task automatic test_directed();
    set_config(4'd3, 1'b1);
    send_request(OP_BASIS, mk_req(0, 0, 0, 17, 0, 0, 32'h8000_0000));
    send_request(OP_BASIS, mk_req(0, 0, 0, 17, 1, 0, 32'h7FFF_FFFF));
    send_request(OP_BASIS, mk_req(0, 0, 0, 17, 2, 0, 32'h0100_0000));
    for (int t = 3; t < 8; t++)
      send_request(OP_BASIS, mk_req(0, 0, 0, 17, t, 0, 32'hFF00_0000));
    send_request(OP_RESPONSE, mk_req(0, 0, 0, 17, 0, 0, 32'hFFFF_FFFF));
    // Same row on both sides: the row gets both contributions and two bumps.
    send_request(OP_PAIR, mk_req(255, 255, 17, 0, 0, 0, 32'h7FFF_FFFF));
    send_request(OP_PAIR, mk_req(0, 255, 255, 17, 0, 0, 32'h8000_0000));
    send_request(OP_PAIR, mk_req(1, 2, 17, 17, 0, 0, 32'h0000_0000));
    send_request(OP_PAIR, mk_req(1, 2, 0, 17, 0, 0, 32'hFF00_0001));
    send_request(OP_PAIR, mk_req(255, 255, 0, 0, 0, 0, 32'h0000_0001));
    send_request(OP_PAIR, mk_req(255, 255, 0, 0, 0, 0, 32'h0100_0000));
    send_request(OP_READ, mk_req(255, 0, 0, 0, 2, 0, 0));
    send_request(OP_READ, mk_req(255, 0, 0, 0, 0, 2, 0));
    send_request(OP_READ, mk_req(255, 0, 0, 0, 2, RHS_COL, 0));
    send_request(OP_READ, mk_req(0, 0, 0, 0, 7, 0, 32'hFFFF_FFFF));
    send_request(OP_READ, mk_req(0, 0, 0, 0, 1, 15, 0));
    send_request(OP_READ, mk_req(1, 0, 0, 0, 3, 1, 0));
    send_request(OP_READ, mk_req(2, 0, 0, 0, 1, 9, 0));
    send_request(OP_READ, mk_req(254, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_phases();
    logic [3:0] tcs [7] = '{4'd15, 4'd0, 4'd8, 4'd1, 4'd3, 4'd5, 4'd2};
    for (int ph = 0; ph < 7; ph++) begin
      set_config(tcs[ph], ph[0]);
      idle_on = (ph != 2);
      for (int k = 0; k < 75; k++)
        send_random((k % 3 == 0) ? 255 : 7);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_results = 1'b1;
        repeat (2000) @(posedge clk);
        hold_results = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_random(7);
    join
  endtask

  // Large same-sign terms into one row until its accumulators saturate.
  task automatic test_saturation();
    set_config(4'd1, 1'b1);
    idle_on = 1'b0;
    for (int t = 0; t < 8; t++)
      send_request(OP_BASIS, mk_req(0, 0, 0, 200, t, 0, 32'h8000_0000));
    send_request(OP_RESPONSE, mk_req(0, 0, 0, 200, 0, 0, 32'h7FFF_FFFF));
    for (int k = 0; k < 560; k++)
      send_request(OP_PAIR, mk_req(9, 9, 200, 200, 0, 0,
                                   32'($urandom_range(32'h7000_0000, 32'h7FFF_FFFF))));
    send_request(OP_READ, mk_req(9, 0, 0, 0, 0, 0, 0));
    send_request(OP_READ, mk_req(9, 0, 0, 0, 0, RHS_COL, 0));
    idle_on = 1'b1;
    set_config(4'd8, 1'b0);
    for (int k = 0; k < 30; k++) send_random(255);
  endtask

  // Result side: draws a stall before each result, or holds off entirely.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        m_tready <= 1'b0;
      end else if (result_gap > 0) begin
        m_tready <= 1'b0;
        result_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got, e;
    if (m_tvalid && m_tready) begin
      result_gap = idle_on ? $urandom_range(0, 7) : 0;
      got = m_tdata[68:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", got.read_value, 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (got.read_value !== e.read_value)
          report_mismatch("read_value", got.read_value, e.read_value);
        if (got.support !== e.support)
          report_mismatch("support", 64'(got.support), 64'(e.support));
        if (got.overflow !== e.overflow)
          report_mismatch("overflow", 64'(got.overflow), 64'(e.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("pairwise_weighted_gram_accumulator_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = '0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    term_count_reg = 4'd1; track_reg = 1'b0; sat_seen = 1'b0;
    error_count = 0; idle_on = 1'b1; hold_results = 1'b0;
    result_gap = 0; quiet_cycles = 0;
    foreach (moment_acc[r, a, b]) moment_acc[r][a][b] = 0;
    foreach (rhs_acc[r, a]) rhs_acc[r][a] = 0;
    foreach (support_cnt[r]) begin
      support_cnt[r] = '0;
      basis_written[r] = '0;
      resp_written[r] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_config(4'd8, 1'b1);
    test_load_points();
    test_directed();
    test_random_phases();
    test_back_pressure();
    test_saturation();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("pairwise_weighted_gram_accumulator_tb: done, clean");
    end else begin
      $display("pairwise_weighted_gram_accumulator_tb: done, errors");
    end
    $finish;
  end

endmodule
